// ===== src/bba_pkg.sv =====
// Package for the block bitmap allocator.
// Types, field widths, command and status codes. No dependencies.
package bba_pkg;

  localparam int BLK_FIELD_W = 12;  // block number fields on the ports
  localparam int CNT_FIELD_W = 13;  // block_count register

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_CHK,
    S_RESP
  } ctrl_state_e;

  typedef struct packed {
    status_e                  status;
    logic [BLK_FIELD_W-1:0]   granted;
  } res_t;

endpackage

// ===== src/bba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bba_ctrl.sv =====
// Allocator sequencer: clear pass, first-fit word scan, free read-modify-write.
// Depends on bba_pkg; drives the bitmap RAM ports.
module bba_ctrl
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     command_i,
  input  logic [BLK_FIELD_W-1:0]   target_block_i,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0] limit_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output res_t                     res_o,
  output logic                     ram_we_o,
  output logic [((NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS > 1 ?
                 $clog2((NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] ram_waddr_o,
  output logic [WORD_BITS-1:0]     ram_wdata_o,
  output logic                     ram_re_o,
  output logic [((NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS > 1 ?
                 $clog2((NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] ram_raddr_o,
  input  logic [WORD_BITS-1:0]     ram_rdata_i
);

  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PTR_W     = $clog2(MAP_WORDS + 1);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int BASE_W    = $clog2(MAP_WORDS * WORD_BITS + WORD_BITS + 1);
  localparam int CMP_A     = (BASE_W > CNT_W) ? BASE_W : CNT_W;
  localparam int CMP_W     = (CMP_A > BLK_FIELD_W) ? CMP_A : BLK_FIELD_W;
  // word index = floor(target / WORD_BITS) by reciprocal multiply, exact for 12-bit targets
  localparam int DIV_SH    = BLK_FIELD_W + BIT_W;
  localparam int DIV_M     = (2 ** DIV_SH + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W    = DIV_SH + 16;

  ctrl_state_e            state_q, state_d;
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic [BASE_W-1:0]      base_q, base_d;
  logic [ADDR_W-1:0]      chk_addr_q, chk_addr_d;
  logic [BLK_FIELD_W-1:0] tgt_q, tgt_d;
  logic [ADDR_W-1:0]      widx_q, widx_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  res_t                   res_q, res_d;

  logic                   accept;
  logic                   tgt_oor;
  logic [PROD_W-1:0]      div_prod;
  logic [15:0]            word_start;
  logic [15:0]            rem_full;
  logic [CMP_W-1:0]       base_ext;
  logic [CMP_W-1:0]       limit_ext;
  logic [CMP_W-1:0]       remain;
  logic                   scan_end;
  logic [WORD_BITS-1:0]   free_bits;
  logic                   found;
  logic [BIT_W-1:0]       found_idx;
  logic [CMP_W-1:0]       granted_full;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  // Datapath: range check, word index, scan word analysis
  always_comb begin
    limit_ext  = CMP_W'(limit_i);
    base_ext   = CMP_W'(base_q);
    tgt_oor    = CMP_W'(target_block_i) >= limit_ext;
    div_prod   = PROD_W'(target_block_i) * PROD_W'(DIV_M);
    word_start = 16'(widx_q) * 16'(WORD_BITS);
    rem_full   = 16'(tgt_q) - word_start;
    scan_end   = base_ext >= limit_ext;
    remain     = limit_ext - base_ext;
    for (int b = 0; b < WORD_BITS; b++) begin
      free_bits[b] = !ram_rdata_i[b] && (CMP_W'(b) < remain);
    end
    found     = |free_bits;
    found_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        found_idx = BIT_W'(b);
      end
    end
    granted_full = base_ext + CMP_W'(found_idx);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (ptr_q == PTR_W'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (command_i == CMD_ALLOC) begin
            state_d = S_SCAN;
          end else if (tgt_oor) begin
            state_d = S_RESP;
          end else begin
            state_d = S_FREE_RD;
          end
        end
      end
      S_SCAN: begin
        if (scan_end || found) begin
          state_d = S_RESP;
        end
      end
      S_FREE_RD:  state_d = S_FREE_CHK;
      S_FREE_CHK: state_d = S_RESP;
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath registers
  always_comb begin
    ptr_d       = ptr_q;
    base_d      = base_q;
    chk_addr_d  = chk_addr_q;
    tgt_d       = tgt_q;
    widx_d      = widx_q;
    bit_d       = bit_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = chk_addr_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q[ADDR_W-1:0];
        ptr_d       = ptr_q + PTR_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          res_d = '{status: ST_OK, granted: '0};
          if (command_i == CMD_ALLOC) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = '0;
            ptr_d       = PTR_W'(1);
            base_d      = '0;
            chk_addr_d  = '0;
          end else if (tgt_oor) begin
            res_d.status = ST_OUT_OF_RANGE;
          end else begin
            tgt_d  = target_block_i;
            widx_d = div_prod[DIV_SH +: ADDR_W];
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          res_d.status = ST_NO_FREE;
        end else if (found) begin
          ram_we_o      = 1'b1;
          ram_waddr_o   = chk_addr_q;
          ram_wdata_o   = ram_rdata_i | (WORD_BITS'(1) << found_idx);
          res_d.granted = granted_full[BLK_FIELD_W-1:0];
        end else begin
          // prefetch the next word while this one is checked
          ram_re_o    = (ptr_q < PTR_W'(MAP_WORDS));
          ram_raddr_o = ptr_q[ADDR_W-1:0];
          chk_addr_d  = ptr_q[ADDR_W-1:0];
          ptr_d       = ptr_q + PTR_W'(1);
          base_d      = base_q + BASE_W'(WORD_BITS);
        end
      end
      S_FREE_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = widx_q;
        bit_d       = rem_full[BIT_W-1:0];
      end
      S_FREE_CHK: begin
        if (ram_rdata_i[bit_q]) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = widx_q;
          ram_wdata_o = ram_rdata_i & ~(WORD_BITS'(1) << bit_q);
        end else begin
          res_d.status = ST_ALREADY_FREE;
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    chk_addr_q <= chk_addr_d;
    tgt_q      <= tgt_d;
    widx_q     <= widx_d;
    bit_q      <= bit_d;
    res_q      <= res_d;
  end

endmodule

// ===== src/block_bitmap_allocator.sv =====
// Top level of the first-fit block bitmap allocator.
// Depends on bba_pkg, bba_ram and bba_ctrl.
//
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+-----------------------------------
//  in       | input     | in_valid_i/in_ready_o | command_i, target_block_i
//  out      | output    | out_valid_o/out_ready_i | granted_block_o, status_o
//  cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_block_count_i
//
// Sequence: allocate scans word by word up to the granting word, or over every word below
//   the count plus one more step when none is free. Free reads the word, then checks and
//   clears its bit; an out-of-range free responds at once. RAM reads give one word a cycle.
// Reset: a clearing pass over all MAP_WORDS words zeroes the bitmap, in_ready_o low.
// Stalls: one item at a time; a finished result sits in the output register, so the next
//   word is taken while out_ready_i is low. cfg writes are taken at any time.
module block_bitmap_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   command_i,
  input  logic [BLK_FIELD_W-1:0] target_block_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [BLK_FIELD_W-1:0] granted_block_o,
  output logic [1:0]             status_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CNT_FIELD_W-1:0] cfg_block_count_i
);

  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int LIM_W     = (CNT_W > CNT_FIELD_W) ? CNT_W : CNT_FIELD_W;

  logic [CNT_FIELD_W-1:0] blk_cnt_q;
  logic [LIM_W-1:0]       cnt_ext;
  logic [CNT_W-1:0]       limit;

  logic                   res_valid;
  logic                   res_ready;
  res_t                   res;

  logic                   out_valid_q;
  res_t                   out_q;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [WORD_BITS-1:0]   ram_rdata;

  // block_count register; the user keeps it only written while idle; the block does not enforce this, so no guard here
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_cnt_q <= CNT_FIELD_W'(4096);
    end else if (cfg_valid_i && cfg_ready_o) begin
      blk_cnt_q <= cfg_block_count_i;
    end
  end

  // a count above capacity behaves as the capacity
  always_comb begin
    cnt_ext = LIM_W'(blk_cnt_q);
    if (cnt_ext > LIM_W'(NUM_BLOCKS)) begin
      limit = CNT_W'(NUM_BLOCKS);
    end else begin
      limit = cnt_ext[CNT_W-1:0];
    end
  end

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .target_block_i (target_block_i),
    .limit_i        (limit),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  // output register: takes a result when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_block_o = out_q.granted;
  assign status_o        = out_q.status;

endmodule
